### rtl/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time block.
// Item structs, config register indexes, FSM states and the saturate helper.
// No dependencies.
package mbe_pkg;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_x;
    logic [7:0] out_y;
    logic       inside_res;
    logic [7:0] escape_iteration;
  } out_item_t;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REAL_ORIGIN = 3'd0,
    REG_IMAG_TOP    = 3'd1,
    REG_REAL_STEP   = 3'd2,
    REG_IMAG_STEP   = 3'd3,
    REG_ITER_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_MUL,
    ST_SET_ADD,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_t;

  localparam logic signed [31:0] RESET_REAL_ORIGIN = -32'sd536870912;
  localparam logic signed [31:0] RESET_IMAG_TOP    = -32'sd80530637;
  localparam logic [30:0]        RESET_REAL_STEP   = 31'd10194080;
  localparam logic [30:0]        RESET_IMAG_STEP   = 31'd10503778;
  localparam logic [7:0]         RESET_ITER_LIMIT  = 8'd255;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

### rtl/mbe_mul3.sv
// Shared multiplier set: three signed 33x33 multipliers with registered products.
// Used for the pixel-to-point products and for zr*zr, zi*zi, zr*zi.
// Depends on nothing.
module mbe_mul3 (
  input  logic               clk,
  input  logic signed [32:0] a0,
  input  logic signed [32:0] b0,
  input  logic signed [32:0] a1,
  input  logic signed [32:0] b1,
  input  logic signed [32:0] a2,
  input  logic signed [32:0] b2,
  output logic signed [63:0] p0,
  output logic signed [63:0] p1,
  output logic signed [63:0] p2
);

  logic signed [65:0] m0;
  logic signed [65:0] m1;
  logic signed [65:0] m2;

  assign m0 = a0 * b0;
  assign m1 = a1 * b1;
  assign m2 = a2 * b2;

  always_ff @(posedge clk) begin
    p0 <= m0[63:0];
    p1 <= m1[63:0];
    p2 <= m2[63:0];
  end

endmodule

### rtl/mandelbrot_escape_test.sv
// Mandelbrot escape-time test for one pixel, top level.
// Uses mbe_pkg and the shared multiplier set mbe_mul3.
//
// Usage:
//   in channel  (in_valid/in_ready, in_item): one pixel coordinate per item.
//   out channel (out_valid/out_ready, out_item): echoed coordinate, inside
//     flag and escape iteration, one item per input item.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//     write only while no item is in flight.
// One item is worked on at a time; in_ready is high only when idle.
// Sequence: c is formed from the pixel-to-point products, which are registered
//   in the multiplier set; each bound test then registers the z products in the
//   multiplier set, then does the bound test and z update; finally the output
//   register is loaded. There are escape_iteration + 1 bound tests on escape,
//   the limit when inside.
// The output register frees the core: a new item is taken while a result
//   waits; a finished item holds in the done state until out is free.
// Reset (rst, synchronous) clears control and loads the default registers.
module mandelbrot_escape_test #(
  parameter int FRAC_BITS  = 28,
  parameter int COORD_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mbe_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output mbe_pkg::out_item_t                 out_item,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data
);
  import mbe_pkg::*;

  localparam int               CB    = (COORD_BITS > 8) ? 8 : COORD_BITS;
  localparam logic [7:0]       CMASK = 8'((16'd1 << CB) - 16'd1);
  localparam logic [63:0]      BOUND = 64'd1 << (2 * FRAC_BITS + 2);

  logic signed [31:0] real_origin;
  logic signed [31:0] imag_top;
  logic [30:0]        real_step;
  logic [30:0]        imag_step;
  logic [7:0]         iteration_limit;

  state_t state;
  state_t state_next;

  logic [7:0]         px;
  logic [7:0]         py;
  logic signed [31:0] c_re;
  logic signed [31:0] c_im;
  logic signed [31:0] zr;
  logic signed [31:0] zi;
  logic [7:0]         count;
  logic               no_escape;

  logic signed [32:0] a0, b0, a1, b1, a2, b2;
  logic signed [63:0] p0, p1, p2;

  logic               take_in;
  logic               load_c;
  logic               escape;
  logic               step_z;
  logic               last_iter;
  logic               finish;
  logic [63:0]        mag2;
  logic signed [63:0] cre_sum;
  logic signed [63:0] cim_sum;
  logic signed [31:0] nr;
  logic signed [31:0] ni;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      real_origin     <= RESET_REAL_ORIGIN;
      imag_top        <= RESET_IMAG_TOP;
      real_step       <= RESET_REAL_STEP;
      imag_step       <= RESET_IMAG_STEP;
      iteration_limit <= RESET_ITER_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_REAL_ORIGIN: real_origin     <= cfg_data;
        REG_IMAG_TOP:    imag_top        <= cfg_data;
        REG_REAL_STEP:   real_step       <= cfg_data[30:0];
        REG_IMAG_STEP:   imag_step       <= cfg_data[30:0];
        REG_ITER_LIMIT:  iteration_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    if (state == ST_SET_MUL) begin
      a0 = signed'({25'd0, px});
      b0 = signed'({2'b00, real_step});
      a1 = signed'({25'd0, py});
      b1 = signed'({2'b00, imag_step});
      a2 = '0;
      b2 = '0;
    end else begin
      a0 = 33'(zr);
      b0 = 33'(zr);
      a1 = 33'(zi);
      b1 = 33'(zi);
      a2 = 33'(zr);
      b2 = 33'(zi);
    end
  end

  mbe_mul3 u_mul (
    .clk (clk),
    .a0  (a0),
    .b0  (b0),
    .a1  (a1),
    .b1  (b1),
    .a2  (a2),
    .b2  (b2),
    .p0  (p0),
    .p1  (p1),
    .p2  (p2)
  );

  // datapath arithmetic
  assign cre_sum   = 64'(real_origin) + p0;
  assign cim_sum   = 64'(imag_top) - p1;
  assign mag2      = unsigned'(p0) + unsigned'(p1);
  assign escape    = mag2 > BOUND;
  assign ni        = sat32((p2 >>> (FRAC_BITS - 1)) + 64'(c_im));
  assign nr        = sat32(((p0 - p1) >>> FRAC_BITS) + 64'(c_re));
  assign last_iter = ({1'b0, count} + 9'd1) == {1'b0, iteration_limit};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_SET_MUL;
      ST_SET_MUL: state_next = ST_SET_ADD;
      ST_SET_ADD: begin
        if (iteration_limit == 8'd0) state_next = ST_DONE;
        else state_next = ST_MUL;
      end
      ST_MUL:     state_next = ST_UPD;
      ST_UPD: begin
        if (escape || last_iter) state_next = ST_DONE;
        else state_next = ST_MUL;
      end
      ST_DONE:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    take_in  = (state == ST_IDLE) && in_valid;
    load_c   = (state == ST_SET_ADD);
    step_z   = (state == ST_UPD) && !escape;
    finish   = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      px <= in_item.pixel_x & CMASK;
      py <= in_item.pixel_y & CMASK;
    end
    if (load_c) begin
      c_re      <= sat32(cre_sum);
      c_im      <= sat32(cim_sum);
      zr        <= sat32(cre_sum);
      zi        <= sat32(cim_sum);
      count     <= 8'd0;
      no_escape <= 1'b1;
    end
    if ((state == ST_UPD) && escape) begin
      no_escape <= 1'b0;
    end
    if (step_z) begin
      zr    <= nr;
      zi    <= ni;
      count <= count + 8'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_item.out_x            <= px;
      out_item.out_y            <= py;
      out_item.inside_res       <= no_escape;
      out_item.escape_iteration <= count;
    end
  end

endmodule

### verif/mandelbrot_escape_test_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for mandelbrot_escape_test: escape-time results checked
// against a fixed-point predictor kept in step with the config writes.
// Depends on mbe_pkg and the RTL of mandelbrot_escape_test.
module mandelbrot_escape_test_tb;
  import mbe_pkg::*;

  localparam int FRAC = 28;
  localparam int COORD = 8;
  localparam logic [63:0] ESCAPE_BOUND = 64'd4 << (2 * FRAC);
  localparam int unsigned HOLD_CYCLES = 3000;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic signed [31:0] cur_origin = RESET_REAL_ORIGIN;
  logic signed [31:0] cur_top = RESET_IMAG_TOP;
  logic [30:0] cur_rstep = RESET_REAL_STEP;
  logic [30:0] cur_istep = RESET_IMAG_STEP;
  logic [7:0] cur_limit = RESET_ITER_LIMIT;

  in_item_t pixel_backlog[$];
  out_item_t escape_due[$];
  out_item_t want;
  int unsigned n_queued = 0;
  int unsigned n_checked = 0;
  int unsigned bad_count = 0;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  logic quiet;

  mandelbrot_escape_test #(
    .FRAC_BITS(FRAC),
    .COORD_BITS(COORD)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL mandelbrot_escape_test");
    $finish;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic out_item_t escape_time(input in_item_t pix);
    longint c_re, c_im, zr, zi, zr2, zi2, nr, ni;
    logic [63:0] ur2, ui2;
    int n;
    logic no_escape;
    out_item_t res;
    c_re = clamp32(longint'(cur_origin) + longint'(pix.pixel_x) * longint'(cur_rstep));
    c_im = clamp32(longint'(cur_top) - longint'(pix.pixel_y) * longint'(cur_istep));
    zr = c_re;
    zi = c_im;
    no_escape = 1'b1;
    for (n = 0; n < int'(cur_limit); n++) begin
      zr2 = zr * zr;
      zi2 = zi * zi;
      ur2 = zr2;
      ui2 = zi2;
      if (ur2 + ui2 > ESCAPE_BOUND) begin
        no_escape = 1'b0;
        break;
      end
      ni = clamp32(((zr * zi) >>> (FRAC - 1)) + c_im);
      nr = clamp32(((zr2 - zi2) >>> FRAC) + c_re);
      zr = nr;
      zi = ni;
    end
    res.out_x = pix.pixel_x;
    res.out_y = pix.pixel_y;
    res.inside_res = no_escape;
    res.escape_iteration = n[7:0];
    return res;
  endfunction

  assign quiet = (cyc >= 20000) && (cyc < 45000);

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        escape_due.push_back(escape_time(in_item));
      end
      if (!in_valid || in_ready) begin
        if (pixel_backlog.size() != 0 && (quiet || $urandom_range(99) >= 22)) begin
          in_valid <= 1'b1;
          in_item <= pixel_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (escape_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("unexpected item x=%0d y=%0d inside=%0d iter=%0d", out_item.out_x,
                     out_item.out_y, out_item.inside_res, out_item.escape_iteration);
          end
        end else begin
          want = escape_due.pop_front();
          n_checked <= n_checked + 1;
          if (out_item.out_x !== want.out_x || out_item.out_y !== want.out_y ||
              out_item.inside_res !== want.inside_res ||
              out_item.escape_iteration !== want.escape_iteration) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("mismatch exp x=%0d y=%0d inside=%0d iter=%0d", want.out_x, want.out_y,
                       want.inside_res, want.escape_iteration);
              $display("         got x=%0d y=%0d inside=%0d iter=%0d", out_item.out_x,
                       out_item.out_y, out_item.inside_res, out_item.escape_iteration);
            end
          end
        end
      end
      // one long back-pressure stretch to fill the block
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && n_checked >= 60) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 22);
      end
    end
  end

  task automatic queue_pixel(input logic [7:0] x, input logic [7:0] y);
    in_item_t pix;
    pix.pixel_x = x;
    pix.pixel_y = y;
    pixel_backlog.push_back(pix);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_checked != n_queued) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_REAL_ORIGIN: cur_origin = data;
      REG_IMAG_TOP:    cur_top = data;
      REG_REAL_STEP:   cur_rstep = data[30:0];
      REG_IMAG_STEP:   cur_istep = data[30:0];
      REG_ITER_LIMIT:  cur_limit = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [31:0] origin, input logic [31:0] top,
                          input logic [31:0] rstep, input logic [31:0] istep,
                          input logic [31:0] limit);
    wait_drained();
    write_reg(REG_REAL_ORIGIN, origin);
    write_reg(REG_IMAG_TOP, top);
    write_reg(REG_REAL_STEP, rstep);
    write_reg(REG_IMAG_STEP, istep);
    write_reg(REG_ITER_LIMIT, limit);
  endtask

  initial begin
    int p;
    int i;
    int origin;
    int top;
    int step;
    logic [31:0] limit;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset view, full limit: corners, inside points and scattered coordinates
    queue_pixel(8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255);
    queue_pixel(8'd0, 8'd255);
    queue_pixel(8'd255, 8'd0);
    queue_pixel(8'd47, 8'd0);
    queue_pixel(8'd52, 8'd0);
    queue_pixel(8'd40, 8'd1);
    queue_pixel(8'd26, 8'd0);
    queue_pixel(8'd170, 8'd85);
    queue_pixel(8'd85, 8'd170);
    queue_pixel(8'd128, 8'd128);
    queue_pixel(8'd127, 8'd1);
    queue_pixel(8'd1, 8'd127);
    queue_pixel(8'd60, 8'd3);

    // c at the range ends: real starts low and imag high, and both saturate at pixel 255
    set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    queue_pixel(8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255);
    queue_pixel(8'd255, 8'd0);
    queue_pixel(8'd0, 8'd255);

    // c starts high on real and low on imag, and saturates that way at pixel 255
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd255);
    queue_pixel(8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0);

    // zero steps: every point is the origin, stays inside
    set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd255);
    queue_pixel(8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255);

    // zero limit: no iteration at all
    set_view(32'hE000_0000, 32'h1000_0000, 32'd4194304, 32'd4194304, 32'd0);
    queue_pixel(8'd10, 8'd20);
    queue_pixel(8'd255, 8'd255);

    for (p = 0; p < 8; p++) begin
      if (p % 2 == 1) begin
        limit = ($urandom & 32'hFFFF_FF00) | $urandom_range(1, 32);
        set_view($urandom, $urandom, $urandom, $urandom, limit);
      end else begin
        origin = -671088640 + int'($urandom_range(0, 134217728));
        top = 402653184 - int'($urandom_range(0, 134217728));
        step = 4194304 >> $urandom_range(0, 3);
        if (p == 2) begin
          limit = 32'd255;
        end else if (p == 4) begin
          limit = 32'd1;
        end else begin
          limit = $urandom_range(2, 64);
        end
        set_view(origin, top, step + int'($urandom_range(0, 4096)),
                 step + int'($urandom_range(0, 4096)), limit);
      end
      for (i = 0; i < 90; i++) begin
        queue_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (600) @(posedge clk);
    if (bad_count == 0 && escape_due.size() == 0) begin
      $display("PASS mandelbrot_escape_test");
    end else begin
      $display("FAIL mandelbrot_escape_test");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mbe_pkg.sv
rtl/mbe_mul3.sv
rtl/mandelbrot_escape_test.sv
verif/mandelbrot_escape_test_tb.sv
